// ===== hw/rtl/sha256_stream_hasher_unit_defines.svh =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit_defines
// assertion macros used by the hasher top module
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shs assertion failed");

// next-cycle implication, checked out of reset
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shs assertion failed");

`endif

// ===== hw/rtl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// types, constants and round functions of the streaming sha-256 hasher
// ----------------------------------------------------------------------------
package shs_pkg;

    // input word: one message byte with its marks
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_word;

    // output word: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_LOAD,
        ST_ROUNDS,
        ST_FOLD,
        ST_OUTPUT
    } t_state;

    // where to go once a block compression is done
    typedef enum logic [1:0] {
        RES_IDLE,
        RES_MARK,
        RES_ZERO,
        RES_OUT
    } t_resume;

    // byte source for the block shift register
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    // commands from controller to datapath
    typedef struct packed {
        logic       shift;
        t_src       src;
        logic       count_bits;
        logic       load_vars;
        logic       round;
        logic       fold;
        logic       restore;
        logic [5:0] round_idx;
        logic [2:0] word_idx;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [5:0] fill;
    } t_status;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_START     = 6'd56;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [5:0] ROUND_LAST    = 6'd63;
    localparam logic [2:0] WORD_LAST     = 3'd7;

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// streaming sha-256 hasher, one message byte per input word
// ----------------------------------------------------------------------------
// Each input word is taken while the unit is idle; the 64th byte of a block
// starts a compression (load, 64 rounds on a single round unit, fold into
// the chaining values) during which no word is taken. An end-of-message
// word starts padding, which shifts one pad byte per cycle (marker, zeros
// up to byte 56 with an extra compression when the block overflows, one
// pause without a shift on reaching byte 56, eight length bytes), then the
// final compression, then the eight digest words, most significant first,
// one per accepted output word; after the last one the unit is ready for
// the next message.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_unit_defines.svh"

module sha256_stream_hasher_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  shs_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output shs_pkg::t_out_word  o_out_word
);
    import shs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // handshake terms for the checks
    logic       eom_take;
    logic       mid_take;
    logic       last_take;
    logic [2:0] out_idx;
    logic [2:0] step_idx;

    assign eom_take  = i_in_valid && o_in_ready && i_in_word.end_of_message;
    assign mid_take  = o_out_valid && i_out_ready && !o_out_word.last_word;
    assign last_take = o_out_valid && i_out_ready && o_out_word.last_word;
    assign out_idx   = o_out_word.word_index;
    assign step_idx  = out_idx + 3'd1;

    // sequencer
    shs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // hashing datapath
    shs_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_word (o_out_word)
    );

    // intake and digest output never overlap
    `SHS_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    // the end of a message always closes intake for padding
    `SHS_ASSERT_NEXT(a_eom_busy, i_clk, i_rst_n, eom_take, !o_in_ready)
    // digest words come in order
    `SHS_ASSERT_NEXT(a_word_order, i_clk, i_rst_n, mid_take, o_out_valid && out_idx == $past(step_idx))
    // the last word returns the unit to intake
    `SHS_ASSERT_NEXT(a_last_done, i_clk, i_rst_n, last_take, !o_out_valid && o_in_ready)

endmodule

// ===== hw/rtl/shs_ctrl.sv =====
// ----------------------------------------------------------------------------
// shs_ctrl
// sequencer of the hasher: intake, padding, compression rounds, digest output
// ----------------------------------------------------------------------------
module shs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  shs_pkg::t_in_word i_in_word,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  shs_pkg::t_status i_status,
    output shs_pkg::t_cmd    o_cmd
);
    import shs_pkg::*;

    t_state     r_state,  n_state;
    t_resume    r_resume, n_resume;
    logic [5:0] r_round,  n_round;
    logic [2:0] r_widx,   n_widx;
    logic       accept;
    logic       fill_last;

    assign accept    = (r_state == ST_IDLE) && i_in_valid;
    assign fill_last = (i_status.fill == FILL_LAST);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_resume <= RES_IDLE;
            r_round  <= '0;
            r_widx   <= '0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
            r_round  <= n_round;
            r_widx   <= n_widx;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_resume = r_resume;
        n_round  = r_round;
        n_widx   = r_widx;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_word.byte_valid && fill_last) begin
                        n_state  = ST_LOAD;
                        n_resume = i_in_word.end_of_message ? RES_MARK : RES_IDLE;
                    end else if (i_in_word.end_of_message) begin
                        n_state = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                if (fill_last) begin
                    n_state  = ST_LOAD;
                    n_resume = RES_ZERO;
                end else begin
                    n_state = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                if (i_status.fill == LEN_START) begin
                    n_state = ST_PAD_LEN;
                end else if (fill_last) begin
                    n_state  = ST_LOAD;
                    n_resume = RES_ZERO;
                end
            end
            ST_PAD_LEN: begin
                if (fill_last) begin
                    n_state  = ST_LOAD;
                    n_resume = RES_OUT;
                end
            end
            ST_LOAD: begin
                n_state = ST_ROUNDS;
                n_round = '0;
            end
            ST_ROUNDS: begin
                n_round = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                case (r_resume)
                    RES_IDLE: n_state = ST_IDLE;
                    RES_MARK: n_state = ST_PAD_MARK;
                    RES_ZERO: n_state = ST_PAD_ZERO;
                    RES_OUT: begin
                        n_state = ST_OUTPUT;
                        n_widx  = '0;
                    end
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_OUTPUT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == WORD_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_in_ready        = (r_state == ST_IDLE);
        o_out_valid       = (r_state == ST_OUTPUT);
        o_cmd             = '0;
        o_cmd.src         = SRC_DATA;
        o_cmd.round_idx   = r_round;
        o_cmd.word_idx    = r_widx;
        case (r_state)
            ST_IDLE: begin
                o_cmd.shift      = accept && i_in_word.byte_valid;
                o_cmd.count_bits = accept && i_in_word.byte_valid;
            end
            ST_PAD_MARK: begin
                o_cmd.shift = 1'b1;
                o_cmd.src   = SRC_MARK;
            end
            ST_PAD_ZERO: begin
                o_cmd.shift = (i_status.fill != LEN_START);
                o_cmd.src   = SRC_ZERO;
            end
            ST_PAD_LEN: begin
                o_cmd.shift = 1'b1;
                o_cmd.src   = SRC_LEN;
            end
            ST_LOAD:   o_cmd.load_vars = 1'b1;
            ST_ROUNDS: o_cmd.round     = 1'b1;
            ST_FOLD:   o_cmd.fold      = 1'b1;
            ST_OUTPUT: o_cmd.restore   = i_out_ready && (r_widx == WORD_LAST);
            default:   o_cmd.shift     = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/shs_datapath.sv =====
// ----------------------------------------------------------------------------
// shs_datapath
// block shift register, rolling schedule, round unit, chaining values, length
// ----------------------------------------------------------------------------
module shs_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shs_pkg::t_in_word i_in_word,
    input  shs_pkg::t_cmd     i_cmd,
    output shs_pkg::t_status  o_status,
    output shs_pkg::t_out_word o_out_word
);
    import shs_pkg::*;

    // block bytes, word 0 at the top; during rounds it is the schedule window
    logic [511:0] r_block;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [31:0]  r_chain [8];
    logic [31:0]  r_v     [8];
    logic [31:0]  r_pre;

    logic [7:0]   in_byte;
    logic [31:0]  w0, w1, w9, w14, w_new;
    logic [31:0]  t1, t2;
    logic [5:0]   next_round;

    assign w0  = r_block[511:480];
    assign w1  = r_block[479:448];
    assign w9  = r_block[223:192];
    assign w14 = r_block[63:32];

    // next schedule word from the window
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

    // round sums; r_pre already holds h + k + w
    assign t1 = r_pre + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]));
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign next_round = i_cmd.round_idx + 6'd1;

    // byte source select
    always_comb begin
        case (i_cmd.src)
            SRC_DATA: in_byte = i_in_word.data_byte;
            SRC_MARK: in_byte = PAD_MARK_BYTE;
            SRC_ZERO: in_byte = 8'h00;
            SRC_LEN:  in_byte = r_bits[63:56];
            default:  in_byte = 8'h00;
        endcase
    end

    // block and schedule window
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_block <= {r_block[503:0], in_byte};
        end else if (i_cmd.round) begin
            r_block <= {r_block[479:0], w_new};
        end
    end

    // fill count, bit length and chaining values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bits <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= IV_TABLE[i];
        end else begin
            if (i_cmd.restore) begin
                r_fill <= '0;
                r_bits <= '0;
                for (int i = 0; i < 8; i++) r_chain[i] <= IV_TABLE[i];
            end else begin
                if (i_cmd.shift) begin
                    r_fill <= r_fill + 6'd1;
                end
                if (i_cmd.count_bits) begin
                    r_bits <= r_bits + 64'd8;
                end else if (i_cmd.shift && (i_cmd.src == SRC_LEN)) begin
                    r_bits <= {r_bits[55:0], 8'h00};
                end
                if (i_cmd.fold) begin
                    for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
                end
            end
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
            r_pre <= r_chain[7] + K_TABLE[0] + w0;
        end else if (i_cmd.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            r_pre  <= r_v[6] + K_TABLE[next_round] + w1;
        end
    end

    assign o_status.fill          = r_fill;
    assign o_out_word.digest_word = r_chain[i_cmd.word_idx];
    assign o_out_word.word_index  = i_cmd.word_idx;
    assign o_out_word.last_word   = (i_cmd.word_idx == WORD_LAST);

endmodule
